### hdl/slfr_pkg.sv
// shared types, constants and helpers of the sync/length/xor frame receiver
package slfr_pkg;

   localparam logic [7:0] SYNC_FIRST_RESET  = 8'hEB;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'h53;

   localparam logic [7:0] TYPE_BANK0 = 8'h06;
   localparam logic [7:0] TYPE_BANK1 = 8'h07;
   localparam logic [7:0] TYPE_BANK2 = 8'h08;

   localparam logic [1:0] BANK0   = 2'd0;
   localparam logic [1:0] BANK1   = 2'd1;
   localparam logic [1:0] BANK2   = 2'd2;
   localparam logic [1:0] NO_BANK = 2'd3;

   localparam logic [0:0] CSR_SYNC_FIRST  = 1'b0;
   localparam logic [0:0] CSR_SYNC_SECOND = 1'b1;

   typedef enum logic [2:0] {
      PS_SYNC1   = 3'd0,
      PS_SYNC2   = 3'd1,
      PS_LEN_LO  = 3'd2,
      PS_LEN_HI  = 3'd3,
      PS_PAYLOAD = 3'd4
   } parse_state_type;

   typedef struct packed {
      logic        wr;
      logic        rd;
   } mem_ctl_type;

   typedef struct packed {
      logic        frame_good;
      logic [1:0]  bank_hit;
      logic [7:0]  frame_type;
      logic [15:0] header_length;
      logic        bad_checksum;
      logic        overflow;
      logic        rd_hit;
   } res_type;

   function automatic logic [1:0] type_to_bank(input logic [7:0] t);
      logic [1:0] b;
      case (t)
         TYPE_BANK0: b = BANK0;
         TYPE_BANK1: b = BANK1;
         TYPE_BANK2: b = BANK2;
         default:    b = NO_BANK;
      endcase
      return b;
   endfunction

endpackage

### hdl/slfr_if.sv
// channel interfaces: request, response and register write
interface slfr_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;
   logic [1:0] bank_sel;
   logic [9:0] read_index;
   modport source(output valid, cmd, rx_byte, bank_sel, read_index, input ready);
   modport sink(input valid, cmd, rx_byte, bank_sel, read_index, output ready);
endinterface

interface slfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_good;
   logic [1:0]  bank_hit;
   logic [7:0]  frame_type;
   logic [15:0] header_length;
   logic        bad_checksum;
   logic        overflow;
   logic [7:0]  read_data;
   modport source(output valid, frame_good, bank_hit, frame_type, header_length,
                  bad_checksum, overflow, read_data, input ready);
   modport sink(input valid, frame_good, bank_hit, frame_type, header_length,
                bad_checksum, overflow, read_data, output ready);
endinterface

interface slfr_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] index;
   logic [7:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

### hdl/slfr_buffer.sv
// frame buffer memory: four slots, one write and one registered read port
module slfr_buffer import slfr_pkg::*; #(
   parameter int AW = 10
) (
   input  logic          clock,
   input  mem_ctl_type   mem_ctl,
   input  logic [AW+1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW+1:0] rd_addr,
   output logic [7:0]    rd_data
);

   localparam int DEPTH = 4 << AW;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/slfr_parser.sv
// frame parser, bank map and sync registers; issues buffer accesses
module slfr_parser import slfr_pkg::*; #(
   parameter int BUF_DEPTH = 1024,
   parameter int AW        = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write,
   input  logic [0:0]    csr_index,
   input  logic [7:0]    csr_data,
   input  logic          fire,
   input  logic          cmd,
   input  logic [7:0]    rx_byte,
   input  logic [1:0]    bank_sel,
   input  logic [9:0]    read_index,
   output res_type       res,
   output mem_ctl_type   mem_ctl,
   output logic [AW+1:0] wr_addr,
   output logic [7:0]    wr_data,
   output logic [AW+1:0] rd_addr
);

   localparam int CW = $clog2(BUF_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);
   localparam logic [15:0] DEPTH_W = 16'(BUF_DEPTH);

   parse_state_type state_ff, state_in;
   logic [7:0]    sync_first_ff, sync_second_ff;
   logic [7:0]    xor_ff, xor_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   pending_ff, pending_in;
   logic [15:0]   header_ff, header_in;
   logic [7:0]    first_ff, first_in;
   logic [1:0]    map_ff [4];
   logic [1:0]    map_in [4];
   logic [15:0]   len_ff [4];
   logic [15:0]   len_in [4];
   logic [3:0]    written_ff, written_in;

   logic [7:0]    first_byte;
   logic [1:0]    hit;
   logic [15:0]   idx_w;
   logic          rd_ok;
   logic          last_byte;
   logic          full;

   assign first_byte = (count_ff == '0) ? rx_byte : first_ff;
   assign hit        = type_to_bank(first_byte);
   assign idx_w      = 16'(read_index);
   assign rd_ok      = written_ff[bank_sel] && (idx_w < len_ff[bank_sel]) && (idx_w < DEPTH_W);
   assign last_byte  = 16'(count_ff) >= pending_ff;
   assign full       = count_ff >= DEPTH_C;

   // next state
   always_comb begin
      state_in = state_ff;
      if (fire && !cmd) begin
         case (state_ff)
            PS_SYNC1:   state_in = (rx_byte == sync_first_ff) ? PS_SYNC2 : PS_SYNC1;
            PS_SYNC2:   state_in = (rx_byte == sync_second_ff) ? PS_LEN_LO : PS_SYNC1;
            PS_LEN_LO:  state_in = PS_LEN_HI;
            PS_LEN_HI:  state_in = PS_PAYLOAD;
            PS_PAYLOAD: state_in = (full || last_byte) ? PS_SYNC1 : PS_PAYLOAD;
            default:    state_in = PS_SYNC1;
         endcase
      end
   end

   // datapath, bank map and buffer accesses
   always_comb begin
      xor_in     = xor_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      header_in  = header_ff;
      first_in   = first_ff;
      map_in     = map_ff;
      len_in     = len_ff;
      written_in = written_ff;
      res        = '0;
      res.bank_hit = NO_BANK;
      mem_ctl    = '0;
      wr_addr    = {map_ff[NO_BANK], count_ff[AW-1:0]};
      wr_data    = rx_byte;
      rd_addr    = {map_ff[bank_sel], idx_w[AW-1:0]};
      if (fire) begin
         if (cmd) begin
            mem_ctl.rd = rd_ok;
            res.rd_hit = rd_ok;
         end else begin
            case (state_ff)
               PS_SYNC1: begin
                  if (rx_byte != sync_first_ff) begin
                     xor_in   = '0;
                     count_in = '0;
                  end
               end
               PS_SYNC2: begin
                  count_in = '0;
                  if (rx_byte != sync_second_ff) begin
                     xor_in = '0;
                  end
               end
               PS_LEN_LO: begin
                  pending_in = {8'h00, rx_byte};
               end
               PS_LEN_HI: begin
                  pending_in = {rx_byte, pending_ff[7:0]};
                  header_in  = {rx_byte, pending_ff[7:0]};
               end
               PS_PAYLOAD: begin
                  if (full) begin
                     res.overflow = 1'b1;
                     xor_in       = '0;
                     count_in     = '0;
                  end else begin
                     mem_ctl.wr = 1'b1;
                     first_in   = first_byte;
                     if (last_byte) begin
                        xor_in   = '0;
                        count_in = '0;
                        if (xor_ff == rx_byte) begin
                           res.frame_good = 1'b1;
                           res.frame_type = first_byte;
                           res.bank_hit   = hit;
                           if (hit != NO_BANK) begin
                              map_in[hit]     = map_ff[NO_BANK];
                              map_in[NO_BANK] = map_ff[hit];
                              len_in[hit]     = pending_ff;
                              written_in[hit] = 1'b1;
                           end
                        end else begin
                           res.bad_checksum = 1'b1;
                        end
                     end else begin
                        count_in = count_ff + CW'(1);
                        xor_in   = xor_ff ^ rx_byte;
                     end
                  end
               end
               default: begin
                  xor_in   = '0;
                  count_in = '0;
               end
            endcase
         end
      end
      res.header_length = header_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= PS_SYNC1;
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
         xor_ff         <= '0;
         count_ff       <= '0;
         pending_ff     <= '0;
         header_ff      <= '0;
         written_ff     <= '0;
         for (int i = 0; i < 4; i++) begin
            map_ff[i] <= 2'(i);
         end
      end else begin
         state_ff   <= state_in;
         xor_ff     <= xor_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
         header_ff  <= header_in;
         written_ff <= written_in;
         map_ff     <= map_in;
         if (csr_write) begin
            case (csr_index)
               CSR_SYNC_FIRST:  sync_first_ff  <= csr_data;
               CSR_SYNC_SECOND: sync_second_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      len_ff   <= len_in;
   end

endmodule

### hdl/slfr_resp.sv
// result pipeline: buffer-read stage and output register
module slfr_resp import slfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  res_type    res,
   input  logic [7:0] rd_data,
   output logic       in_ready,
   slfr_rsp_if.source rsp_bus
);

   logic    s1_valid_ff, s1_valid_in;
   res_type s1_res_ff;
   logic    out_valid_ff, out_valid_in;
   res_type out_res_ff;
   logic [7:0] out_rd_ff;
   logic    out_load;

   assign out_load = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign in_ready = !s1_valid_ff || out_load;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (fire) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_res_ff <= res;
      end
      if (out_load) begin
         out_res_ff <= s1_res_ff;
         out_rd_ff  <= s1_res_ff.rd_hit ? rd_data : 8'h00;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.frame_good    = out_res_ff.frame_good;
   assign rsp_bus.bank_hit      = out_res_ff.bank_hit;
   assign rsp_bus.frame_type    = out_res_ff.frame_type;
   assign rsp_bus.header_length = out_res_ff.header_length;
   assign rsp_bus.bad_checksum  = out_res_ff.bad_checksum;
   assign rsp_bus.overflow      = out_res_ff.overflow;
   assign rsp_bus.read_data     = out_rd_ff;

endmodule

### hdl/sync_length_xor_frame_receiver.sv
// top level of the sync/length/xor frame receiver
//
//   channel   direction  carries
//   req_bus   in         cmd, rx_byte, bank_sel, read_index
//   rsp_bus   out        frame_good, bank_hit, frame_type, header_length,
//                        bad_checksum, overflow, read_data
//   csr_bus   in         index (0 sync_first, 1 sync_second), data
//
// one item per cycle while the response side takes results; each result passes
// the read stage (parser/buffer access), then buffer read data into the output register
// synchronous reset, no clearing pass; csr writes always taken
// a stalled response holds the read stage, which then holds req ready low
module sync_length_xor_frame_receiver import slfr_pkg::*; #(
   parameter int BUF_DEPTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   slfr_req_if.sink   req_bus,
   slfr_rsp_if.source rsp_bus,
   slfr_csr_if.sink   csr_bus
);

   localparam int AW = $clog2(BUF_DEPTH);

   logic          fire;
   logic          in_ready;
   res_type       res;
   mem_ctl_type   mem_ctl;
   logic [AW+1:0] wr_addr;
   logic [AW+1:0] rd_addr;
   logic [7:0]    wr_data;
   logic [7:0]    rd_data;

   assign req_bus.ready = in_ready;
   assign csr_bus.ready = 1'b1;
   assign fire          = req_bus.valid && in_ready;

   slfr_parser #(
      .BUF_DEPTH(BUF_DEPTH),
      .AW       (AW)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .fire      (fire),
      .cmd       (req_bus.cmd),
      .rx_byte   (req_bus.rx_byte),
      .bank_sel  (req_bus.bank_sel),
      .read_index(req_bus.read_index),
      .res       (res),
      .mem_ctl   (mem_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr)
   );

   slfr_buffer #(
      .AW(AW)
   ) u_buffer (
      .clock  (clock),
      .mem_ctl(mem_ctl),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   slfr_resp u_resp (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .res     (res),
      .rd_data (rd_data),
      .in_ready(in_ready),
      .rsp_bus (rsp_bus)
   );

endmodule

### bench/frame_rx_monitor.sv
// result monitor: predicts each response of the frame receiver and compares it
module frame_rx_monitor import slfr_pkg::*; #(
   parameter int BUF_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   slfr_req_if         req_bus,
   slfr_rsp_if         rsp_bus,
   slfr_csr_if         csr_bus,
   output int unsigned expected_left,
   output int unsigned mismatches
);

   typedef struct packed {
      logic        frame_good;
      logic [1:0]  bank_hit;
      logic [7:0]  frame_type;
      logic [15:0] header_length;
      logic        bad_checksum;
      logic        overflow;
      logic [7:0]  read_data;
   } rx_result_t;

   logic [7:0]      sync_a;
   logic [7:0]      sync_b;
   parse_state_type pstate;
   logic [7:0]      xor_acc;
   logic [15:0]     len_pending;
   logic [15:0]     len_header;
   int unsigned     stored;
   logic [7:0]      slot_mem [4][BUF_DEPTH];
   logic [1:0]      slot_of [4];
   logic [15:0]     bank_len [3];
   bit              bank_valid [3];
   rx_result_t      pending_results [$];

   function automatic void back_to_hunt();
      pstate = PS_SYNC1;
      xor_acc = '0;
      stored = 0;
   endfunction

   function automatic rx_result_t step_receiver(input logic cmd, input logic [7:0] b,
                                                input logic [1:0] sel,
                                                input logic [9:0] idx);
      rx_result_t r;
      logic [1:0] slot;
      logic [1:0] old;
      r = '0;
      r.bank_hit = NO_BANK;
      if (cmd) begin
         if (sel != NO_BANK && bank_valid[sel] && 32'(idx) < 32'(bank_len[sel])
             && 32'(idx) < BUF_DEPTH)
            r.read_data = slot_mem[slot_of[sel]][idx];
      end else begin
         case (pstate)
            PS_SYNC1: begin
               if (b == sync_a) pstate = PS_SYNC2;
               else back_to_hunt();
            end
            PS_SYNC2: begin
               if (b == sync_b) begin
                  pstate = PS_LEN_LO;
                  stored = 0;
               end else begin
                  back_to_hunt();
               end
            end
            PS_LEN_LO: begin
               len_pending = {8'h00, b};
               pstate = PS_LEN_HI;
            end
            PS_LEN_HI: begin
               len_pending[15:8] = b;
               len_header = len_pending;
               pstate = PS_PAYLOAD;
            end
            PS_PAYLOAD: begin
               slot = slot_of[NO_BANK];
               if (stored >= BUF_DEPTH) begin
                  r.overflow = 1'b1;
                  back_to_hunt();
               end else begin
                  slot_mem[slot][stored] = b;
                  stored++;
                  if (stored >= 32'(len_pending) + 1) begin
                     if (xor_acc == b) begin
                        r.frame_good = 1'b1;
                        r.frame_type = slot_mem[slot][0];
                        case (r.frame_type)
                           TYPE_BANK0: r.bank_hit = BANK0;
                           TYPE_BANK1: r.bank_hit = BANK1;
                           TYPE_BANK2: r.bank_hit = BANK2;
                           default:    r.bank_hit = NO_BANK;
                        endcase
                        // bank takes the receive slot, its old slot becomes the receive slot
                        if (r.bank_hit != NO_BANK) begin
                           old = slot_of[r.bank_hit];
                           slot_of[r.bank_hit] = slot;
                           slot_of[NO_BANK] = old;
                           bank_len[r.bank_hit] = len_pending;
                           bank_valid[r.bank_hit] = 1'b1;
                        end
                     end else begin
                        r.bad_checksum = 1'b1;
                     end
                     back_to_hunt();
                  end else begin
                     xor_acc ^= b;
                  end
               end
            end
            default: back_to_hunt();
         endcase
      end
      r.header_length = len_header;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rx_result_t got;
      rx_result_t want;
      if (reset) begin
         sync_a = SYNC_FIRST_RESET;
         sync_b = SYNC_SECOND_RESET;
         back_to_hunt();
         len_pending = '0;
         len_header = '0;
         for (int i = 0; i < 4; i++) slot_of[i] = 2'(i);
         for (int i = 0; i < 3; i++) begin
            bank_len[i] = '0;
            bank_valid[i] = 1'b0;
         end
         pending_results.delete();
         mismatches = 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_SYNC_FIRST:  sync_a = csr_bus.data;
               CSR_SYNC_SECOND: sync_b = csr_bus.data;
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.frame_good, rsp_bus.bank_hit, rsp_bus.frame_type,
                    rsp_bus.header_length, rsp_bus.bad_checksum, rsp_bus.overflow,
                    rsp_bus.read_data};
            if (pending_results.size() == 0) begin
               mismatches = mismatches + 1;
               $display("%0t: rsp transfer with nothing expected, actual good=%0d bank=%0d",
                        $time, got.frame_good, got.bank_hit,
                        " type=%h len=%h bad=%0d ovf=%0d rd=%h",
                        got.frame_type, got.header_length, got.bad_checksum,
                        got.overflow, got.read_data);
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  mismatches = mismatches + 1;
                  $display("%0t: mismatch expected good=%0d bank=%0d type=%h len=%h",
                           $time, want.frame_good, want.bank_hit, want.frame_type,
                           want.header_length, " bad=%0d ovf=%0d rd=%h",
                           want.bad_checksum, want.overflow, want.read_data,
                           " actual good=%0d bank=%0d type=%h len=%h",
                           got.frame_good, got.bank_hit, got.frame_type,
                           got.header_length, " bad=%0d ovf=%0d rd=%h",
                           got.bad_checksum, got.overflow, got.read_data);
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            pending_results.push_back(step_receiver(req_bus.cmd, req_bus.rx_byte,
                                                    req_bus.bank_sel, req_bus.read_index));
      end
      expected_left <= pending_results.size();
   end

endmodule

### bench/tb.sv
// testbench top: frame and read stimulus, response stalls and the final verdict
module tb;
   import slfr_pkg::*;

   localparam int BUF_DEPTH = 1024;
   localparam int LONG_HOLD = 240;

   logic        clock;
   logic        reset;
   logic        hold_go;
   bit          no_gaps;
   int          burst_left;
   int unsigned sent;
   logic [7:0]  cur_first;
   logic [7:0]  cur_second;
   int unsigned expected_left;
   int unsigned mismatches;

   slfr_req_if req_bus();
   slfr_rsp_if rsp_bus();
   slfr_csr_if csr_bus();

   sync_length_xor_frame_receiver #(.BUF_DEPTH(BUF_DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   frame_rx_monitor #(.BUF_DEPTH(BUF_DEPTH)) rx_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_bus       (csr_bus),
      .expected_left (expected_left),
      .mismatches    (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 500000);
      $display("status: fail");
      $finish;
   end

   // response side: random stall patterns, one long hold-off when asked
   initial begin : sink_side
      int  mode;
      int  run;
      int  tick;
      bit  held;
      mode = 0;
      run = 0;
      tick = 0;
      held = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !held) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if (run == 0) begin
               mode = $urandom_range(0, 3);
               run = $urandom_range(4, 64);
            end
            run--;
            tick++;
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= (tick % 3 == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   task automatic send_item(input logic cmd, input logic [7:0] b, input logic [1:0] sel,
                            input logic [9:0] idx);
      int gap;
      if (burst_left == 0) begin
         gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.rx_byte    <= b;
      req_bus.bank_sel   <= sel;
      req_bus.read_index <= idx;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      burst_left--;
      sent++;
   endtask

   task automatic rx(input logic [7:0] b);
      send_item(1'b0, b, 2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)));
   endtask

   task automatic read_bank(input logic [1:0] sel, input logic [9:0] idx);
      send_item(1'b1, 8'($urandom), sel, idx);
   endtask

   task automatic random_read();
      read_bank(2'($urandom_range(0, 3)), ($urandom_range(0, 3) == 0) ?
                10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 47)));
   endtask

   // lengths from BUF_DEPTH up stop after one byte past the buffer
   task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len,
                             input bit corrupt);
      logic [7:0] acc;
      logic [7:0] b;
      acc = '0;
      rx(cur_first);
      rx(cur_second);
      rx(len[7:0]);
      rx(len[15:8]);
      for (int i = 0; i < int'(len) && i < BUF_DEPTH; i++) begin
         b = (i == 0) ? ftype : 8'($urandom);
         if ($urandom_range(0, 9) == 0) random_read();
         rx(b);
         acc ^= b;
      end
      rx(corrupt ? acc ^ 8'($urandom_range(1, 255)) : acc);
   endtask

   task automatic random_traffic(input int unsigned n);
      int unsigned target;
      int          pick;
      logic [7:0]  b;
      logic [7:0]  ft;
      logic [15:0] len;
      target = sent + n;
      while (sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            case ($urandom_range(0, 5))
               0:       ft = TYPE_BANK0;
               1:       ft = TYPE_BANK1;
               2:       ft = TYPE_BANK2;
               3:       ft = 8'h00;
               4:       ft = 8'hFF;
               default: ft = 8'($urandom);
            endcase
            len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3))
                                              : 16'($urandom_range(1, 40));
            send_frame(ft, len, $urandom_range(0, 4) == 0);
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 4)) random_read();
         end else if (pick < 90) begin
            // line noise that cannot start a frame
            repeat ($urandom_range(1, 3)) begin
               b = $urandom;
               if (b == cur_first) b = ~b;
               rx(b);
            end
         end else if (pick < 96) begin
            rx(cur_first);
            b = $urandom;
            if (b == cur_second) b = ~b;
            rx(b);
         end else begin
            // truncated frame, the next bytes finish it
            rx(cur_first);
            rx(cur_second);
            rx(8'($urandom_range(4, 20)));
            rx(8'h00);
            repeat ($urandom_range(1, 3)) rx(8'($urandom));
         end
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_left != 0);
   endtask

   task automatic program_sync(input logic [7:0] first, input logic [7:0] second);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_SYNC_FIRST;
      csr_bus.data  <= first;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.index <= CSR_SYNC_SECOND;
      csr_bus.data  <= second;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      cur_first = first;
      cur_second = second;
   endtask

   initial begin : stimulus
      reset              <= 1'b1;
      hold_go            <= 1'b0;
      req_bus.valid      <= 1'b0;
      req_bus.cmd        <= 1'b0;
      req_bus.rx_byte    <= '0;
      req_bus.bank_sel   <= '0;
      req_bus.read_index <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= CSR_SYNC_FIRST;
      csr_bus.data       <= '0;
      no_gaps = 1'b0;
      burst_left = 0;
      sent = 0;
      cur_first = SYNC_FIRST_RESET;
      cur_second = SYNC_SECOND_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty banks, zero length, broken sync, good and bad checksum
      read_bank(BANK0, 10'd0);
      read_bank(NO_BANK, 10'd5);
      send_frame(8'h00, 16'd0, 1'b0);
      rx(cur_first);
      rx(cur_first);
      rx(cur_second);
      send_frame(TYPE_BANK0, 16'd2, 1'b0);
      send_frame(TYPE_BANK2, 16'd1, 1'b1);
      read_bank(BANK0, 10'd1);
      read_bank(BANK0, 10'd2);

      random_traffic(200);
      drain();

      program_sync(8'h00, 8'hFF);
      random_traffic(150);
      read_bank(BANK1, 10'd0);
      drain();

      program_sync(8'hFF, 8'h00);
      random_traffic(100);
      drain();

      program_sync(8'($urandom), 8'($urandom));
      // back-to-back offers while the response side holds off
      hold_go <= 1'b1;
      no_gaps = 1'b1;
      random_traffic(250);
      no_gaps = 1'b0;
      random_traffic(50);

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
